@@ rtl/p2fb_pkg.sv @@
package p2fb_pkg;

  // Screen geometry
  localparam int unsigned WIDTH  = 256;
  localparam int unsigned HEIGHT = 128;

  // Pixel count and packed byte count (four pixels to a byte)
  localparam int unsigned NUM_PIX     = WIDTH * HEIGHT;
  localparam int unsigned STORE_BYTES = (NUM_PIX + 3) / 4;

  // Address widths
  localparam int unsigned PIX_W  = $clog2(NUM_PIX);
  localparam int unsigned ADDR_W = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
  localparam int unsigned X_W    = (WIDTH > 1) ? $clog2(WIDTH) : 1;
  localparam int unsigned Y_W    = (HEIGHT > 1) ? $clog2(HEIGHT) : 1;

  // Reset value of the init color register
  localparam logic [1:0] INIT_COLOR_RST = 2'd3;

  // Item kinds
  typedef enum logic [1:0] {
    KIND_CLEAR = 2'd0,
    KIND_SET   = 2'd1,
    KIND_GET   = 2'd2,
    KIND_RAW   = 2'd3
  } kind_e;

  // Location of one pixel in the store
  typedef struct packed {
    logic              hit;   // on screen
    logic [ADDR_W-1:0] addr;  // packed byte index
    logic [1:0]        pos;   // pixel slot, 0 is bits 7..6
  } loc_t;

  // Color repeated into all four slots of a byte
  function automatic logic [7:0] replicate(input logic [1:0] c);
    return {c, c, c, c};
  endfunction

endpackage

@@ rtl/p2fb_ram.sv @@
module p2fb_ram #(
  parameter int unsigned DataW = 8,
  parameter int unsigned Depth = 8192,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [DataW-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [DataW-1:0] rdata_o
);

  logic [DataW-1:0] mem_q [Depth];
  logic [DataW-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read, old data on a same-address write
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/p2fb_locate.sv @@
module p2fb_locate
  import p2fb_pkg::*;
(
  input  logic [15:0] x_i,
  input  logic [15:0] y_i,
  output loc_t        loc_o
);

  logic            x_ok;
  logic            y_ok;
  logic [PIX_W-1:0] idx;

  // Bounds check on signed coordinates
  assign x_ok = !x_i[15] && (x_i[14:0] < 15'(WIDTH));
  assign y_ok = !y_i[15] && (y_i[14:0] < 15'(HEIGHT));

  // Linear pixel index y * WIDTH + x
  assign idx = PIX_W'(PIX_W'(y_i[Y_W-1:0]) * PIX_W'(WIDTH)) + PIX_W'(x_i[X_W-1:0]);

  assign loc_o.hit  = x_ok && y_ok;
  assign loc_o.addr = ADDR_W'(idx[PIX_W-1:2]);
  assign loc_o.pos  = idx[1:0];

endmodule

@@ rtl/packed_2bpp_framebuffer.sv @@
// Channel  Direction  Handshake              Payload
// in       input      in_valid_i/in_ready_o  kind_i x_i y_i color_i byte_addr_i
// out      output     out_valid_o/out_ready_i pixel_o byte_data_o
// cfg      input      cfg_we_i (no wait)     cfg_wdata_i (init_color)
//
// Set, get and raw read take one item per cycle: the read is issued at accept
// and its byte is used in stage 1, where a set writes it back; a
// same-byte write just ahead is forwarded. Results leave through the output
// register. Clear sweeps the store one byte a cycle with no item accepted;
// after reset the same fill runs with init_color.
// A stalled result holds stage 1 and with it the input.
module packed_2bpp_framebuffer
  import p2fb_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  kind_i,
  input  logic [15:0] x_i,
  input  logic [15:0] y_i,
  input  logic [1:0]  color_i,
  input  logic [12:0] byte_addr_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  pixel_o,
  output logic [7:0]  byte_data_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_wdata_i
);

  typedef enum logic [1:0] {
    ST_BOOT,
    ST_SWEEP,
    ST_RUN
  } state_e;

  state_e            state_q, state_d;
  logic [ADDR_W-1:0] sweep_cnt_q, sweep_cnt_d;
  logic [1:0]        sweep_color_q, sweep_color_d;
  logic [1:0]        init_color_q;

  // Stage 1: item whose byte returns from the RAM
  logic              s1_valid_q;
  kind_e             s1_kind_q;
  logic              s1_hit_q;
  logic [ADDR_W-1:0] s1_addr_q;
  logic [1:0]        s1_pos_q;
  logic [1:0]        s1_color_q;
  logic              fwd_q;
  logic [7:0]        fwd_data_q;

  // Output register
  logic              out_valid_q;
  logic [1:0]        pixel_q;
  logic [7:0]        byte_q;

  kind_e             in_kind;
  loc_t              loc;
  logic              accept;
  logic              in_hit;
  logic [ADDR_W-1:0] in_addr;
  logic              s1_res;
  logic              s1_go;
  logic              s1_wr;
  logic [7:0]        s1_byte;
  logic [7:0]        wr_byte;
  logic [1:0]        rd_pixel;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [7:0]        ram_wdata;
  logic [7:0]        ram_rdata;

  p2fb_locate u_locate (
    .x_i   (x_i),
    .y_i   (y_i),
    .loc_o (loc)
  );

  p2fb_ram #(
    .DataW (8),
    .Depth (STORE_BYTES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (accept && in_hit),
    .raddr_i (in_addr),
    .rdata_o (ram_rdata)
  );

  // Input decode
  assign in_kind = kind_e'(kind_i);
  always_comb begin
    if (in_kind == KIND_RAW) begin
      in_hit  = (32'(byte_addr_i) < STORE_BYTES);
      in_addr = ADDR_W'(byte_addr_i);
    end else begin
      in_hit  = loc.hit;
      in_addr = loc.addr;
    end
  end

  // Stage 1 flow
  assign s1_res = (s1_kind_q == KIND_GET) || (s1_kind_q == KIND_RAW);
  assign s1_go  = s1_valid_q && (!s1_res || !out_valid_q || out_ready_i);
  assign s1_wr  = s1_valid_q && (s1_kind_q == KIND_SET) && s1_hit_q;

  assign in_ready_o = (state_q == ST_RUN) && (!s1_valid_q || s1_go);
  assign accept     = in_valid_i && in_ready_o;

  // Byte seen by stage 1, forwarded when the item ahead wrote it
  assign s1_byte = fwd_q ? fwd_data_q : ram_rdata;

  // Pixel read and pixel replace
  always_comb begin
    rd_pixel = 2'd0;
    wr_byte  = s1_byte;
    for (int i = 0; i < 4; i++) begin
      if (s1_pos_q == 2'(i)) begin
        rd_pixel             = s1_byte[2*(3-i) +: 2];
        wr_byte[2*(3-i) +: 2] = s1_color_q;
      end
    end
  end

  // Write port: sweep or stage 1 write-back
  always_comb begin
    if (state_q == ST_SWEEP) begin
      ram_we    = 1'b1;
      ram_waddr = sweep_cnt_q;
      ram_wdata = replicate(sweep_color_q);
    end else begin
      ram_we    = s1_wr;
      ram_waddr = s1_addr_q;
      ram_wdata = wr_byte;
    end
  end

  // Sequencer: reset fill, clear sweep, normal run
  always_comb begin
    state_d       = state_q;
    sweep_cnt_d   = sweep_cnt_q;
    sweep_color_d = sweep_color_q;
    case (state_q)
      ST_BOOT: begin
        sweep_color_d = init_color_q;
        sweep_cnt_d   = '0;
        state_d       = ST_SWEEP;
      end
      ST_SWEEP: begin
        sweep_cnt_d = sweep_cnt_q + 1'b1;
        if (32'(sweep_cnt_q) == STORE_BYTES - 1) begin
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        if (accept && (in_kind == KIND_CLEAR)) begin
          sweep_color_d = color_i;
          sweep_cnt_d   = '0;
          state_d       = ST_SWEEP;
        end
      end
      default: begin
        state_d = ST_BOOT;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_BOOT;
      init_color_q <= INIT_COLOR_RST;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        init_color_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    sweep_cnt_q   <= sweep_cnt_d;
    sweep_color_q <= sweep_color_d;
  end

  // Stage 1 control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= (in_kind != KIND_CLEAR);
    end else if (s1_go) begin
      s1_valid_q <= 1'b0;
    end
  end

  // Stage 1 payload, with forwarding from the write going on now
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_kind_q  <= in_kind;
      s1_hit_q   <= in_hit;
      s1_addr_q  <= in_addr;
      s1_pos_q   <= loc.pos;
      s1_color_q <= color_i;
      fwd_q      <= s1_wr && (s1_addr_q == in_addr);
      fwd_data_q <= wr_byte;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_go && s1_res) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go && s1_res) begin
      pixel_q <= (s1_kind_q == KIND_GET && s1_hit_q) ? rd_pixel : 2'd0;
      byte_q  <= (s1_kind_q == KIND_RAW && s1_hit_q) ? s1_byte : 8'd0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign pixel_o     = pixel_q;
  assign byte_data_o = byte_q;

endmodule

@@ verif/tb_packed_2bpp_framebuffer.sv @@
`timescale 1ns / 1ps

module tb_packed_2bpp_framebuffer;
  import p2fb_pkg::*;

  // Run controls
  localparam int unsigned IDLE_LIMIT   = 40000;
  localparam int unsigned SETTLE_WAIT  = STORE_BYTES + 16;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned PHASE_ITEMS  = 330;
  localparam int unsigned FLOOD_ITEMS  = 40;

  // One returned item
  typedef struct packed {
    logic [1:0] pixel;
    logic [7:0] byte_data;
  } fb_result_t;

  // Shadow framebuffer and queue of pending read results
  class fb_scoreboard;
    logic [7:0]  fb_bytes [STORE_BYTES];
    logic [1:0]  init_color;
    fb_result_t  expected_q[$];
    int unsigned errors;
    int unsigned checked;
    int unsigned kind_count [4];

    function new();
      init_color = INIT_COLOR_RST;
      foreach (fb_bytes[i]) fb_bytes[i] = {4{init_color}};
      errors  = 0;
      checked = 0;
      foreach (kind_count[i]) kind_count[i] = 0;
    endfunction

    // Only picked up by the fill at the next reset
    function void write_init_color(logic [1:0] v);
      init_color = v;
    endfunction

    function bit locate(int px, int py, output int unsigned bidx, output int unsigned shift);
      int unsigned idx;
      bidx  = 0;
      shift = 0;
      if (px < 0 || px >= int'(WIDTH) || py < 0 || py >= int'(HEIGHT)) return 0;
      idx   = py * WIDTH + px;
      bidx  = idx >> 2;
      shift = (3 - (idx & 3)) * 2;
      return bidx < STORE_BYTES;
    endfunction

    function void note_item(kind_e kind, logic [15:0] x, logic [15:0] y,
                            logic [1:0] color, logic [12:0] addr);
      int          px;
      int          py;
      int unsigned bidx;
      int unsigned shift;
      fb_result_t  r;
      px = int'($signed(x));
      py = int'($signed(y));
      r  = '0;
      kind_count[kind]++;
      case (kind)
        KIND_CLEAR: begin
          foreach (fb_bytes[i]) fb_bytes[i] = {4{color}};
        end
        KIND_SET: begin
          // off-screen writes are dropped
          if (locate(px, py, bidx, shift)) fb_bytes[bidx][shift +: 2] = color;
        end
        KIND_GET: begin
          if (locate(px, py, bidx, shift)) r.pixel = fb_bytes[bidx][shift +: 2];
          expected_q.push_back(r);
        end
        default: begin
          if (addr < STORE_BYTES) r.byte_data = fb_bytes[addr];
          expected_q.push_back(r);
        end
      endcase
    endfunction

    function void flag(string what, int unsigned exp, int unsigned act);
      errors++;
      if (errors <= 10)
        $display("[%0t] mismatch %s: expected %0h got %0h", $time, what, exp, act);
    endfunction

    function void check_result(logic [1:0] pixel, logic [7:0] byte_data);
      fb_result_t exp;
      if (expected_q.size() == 0) begin
        flag("unexpected result, pixel/byte_data", 0, {pixel, byte_data});
        return;
      end
      exp = expected_q.pop_front();
      checked++;
      if (pixel !== exp.pixel) flag("pixel", exp.pixel, pixel);
      if (byte_data !== exp.byte_data) flag("byte_data", exp.byte_data, byte_data);
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni     = 1'b0;
  logic        in_valid   = 1'b0;
  logic        in_ready;
  logic [1:0]  kind       = KIND_GET;
  logic [15:0] x          = '0;
  logic [15:0] y          = '0;
  logic [1:0]  color      = '0;
  logic [12:0] byte_addr  = '0;
  logic        out_valid;
  logic        out_ready  = 1'b0;
  logic [1:0]  pixel;
  logic [7:0]  byte_data;
  logic        cfg_we     = 1'b0;
  logic [1:0]  cfg_wdata  = '0;

  fb_scoreboard sb;
  int unsigned  send_idle_pct = 29;
  int unsigned  recv_idle_pct = 73;
  bit           hold_req      = 1'b0;
  int unsigned  idle_cycles   = 0;
  logic [15:0]  hot_x = '0;
  logic [15:0]  hot_y = '0;

  packed_2bpp_framebuffer i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .kind_i      (kind),
    .x_i         (x),
    .y_i         (y),
    .color_i     (color),
    .byte_addr_i (byte_addr),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .pixel_o     (pixel),
    .byte_data_o (byte_data),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  // 2 ns clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Monitor both channels
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && in_ready)
        sb.note_item(kind_e'(kind), x, y, color, byte_addr);
      if (out_valid && out_ready)
        sb.check_result(pixel, byte_data);
    end
  end

  // Watchdog on cycles without any accepted item or taken result
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout after %0d cycles without progress", idle_cycles);
        $display("tb_packed_2bpp_framebuffer: errors");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Receiver: random back-pressure, or one long hold-off on request
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk_i);
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Offer one item; valid stays up after accept until the next gap
  task automatic send_item(kind_e k, logic [15:0] sx, logic [15:0] sy,
                           logic [1:0] c, logic [12:0] a);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid  <= 1'b1;
    kind      <= k;
    x         <= sx;
    y         <= sy;
    color     <= c;
    byte_addr <= a;
    do @(posedge clk_i); while (!in_ready);
  endtask

  // Drain results, then cover a clear sweep that may still run
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_WAIT) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic [1:0] v);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    sb.write_init_color(v);
  endtask

  // Mostly on screen, some just past the edges, some anywhere
  function automatic logic [15:0] pick_coord(int unsigned lim);
    int unsigned r;
    r = $urandom_range(99);
    if (r < 80) return 16'($urandom_range(lim - 1));
    if (r < 90) return 16'(int'($urandom_range(lim + 3)) - 2);
    return 16'($urandom);
  endfunction

  task automatic random_item();
    int unsigned r;
    kind_e       k;
    logic [15:0] sx;
    logic [15:0] sy;
    logic [12:0] a;
    r = $urandom_range(999);
    if (r < 5)        k = KIND_CLEAR;
    else if (r < 420) k = KIND_SET;
    else if (r < 750) k = KIND_GET;
    else              k = KIND_RAW;
    // move the hot byte now and then
    if ($urandom_range(9) == 0) begin
      hot_x = 16'($urandom_range(WIDTH - 1));
      hot_y = 16'($urandom_range(HEIGHT - 1));
    end
    if ($urandom_range(99) < 30) begin
      sx = {hot_x[15:2], 2'($urandom)};
      sy = hot_y;
      a  = 13'((int'(hot_y) * WIDTH + int'(hot_x)) >> 2);
    end else begin
      sx = pick_coord(WIDTH);
      sy = pick_coord(HEIGHT);
      a  = 13'($urandom);
    end
    send_item(k, sx, sy, 2'($urandom), a);
  endtask

  initial begin
    sb = new();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset fill runs first
    settle();
    cfg_write(2'd0);

    // Directed: reset contents, corners, off-screen, clear, write-then-read
    send_item(KIND_RAW,   16'd0,    16'd0,    2'd0, 13'd0);
    send_item(KIND_RAW,   16'd0,    16'd0,    2'd0, 13'h1FFF);
    send_item(KIND_GET,   16'd0,    16'd0,    2'd0, 13'd0);
    send_item(KIND_GET,   16'd255,  16'd127,  2'd0, 13'd0);
    send_item(KIND_SET,   16'd0,    16'd0,    2'd0, 13'd0);
    send_item(KIND_SET,   16'd1,    16'd0,    2'd2, 13'd0);
    send_item(KIND_SET,   16'd3,    16'd0,    2'd1, 13'd0);
    send_item(KIND_SET,   16'd255,  16'd127,  2'd1, 13'h1FFF);
    send_item(KIND_GET,   16'd1,    16'd0,    2'd0, 13'd0);
    send_item(KIND_RAW,   16'd0,    16'd0,    2'd0, 13'd0);
    send_item(KIND_RAW,   16'd0,    16'd0,    2'd0, 13'h1FFF);
    send_item(KIND_SET,   16'hFFFF, 16'd0,    2'd0, 13'd0);
    send_item(KIND_SET,   16'd256,  16'd0,    2'd0, 13'd0);
    send_item(KIND_SET,   16'd0,    16'd128,  2'd0, 13'd0);
    send_item(KIND_SET,   16'h7FFF, 16'h8000, 2'd0, 13'd0);
    send_item(KIND_GET,   16'hFFFF, 16'd5,    2'd3, 13'd0);
    send_item(KIND_GET,   16'd5,    16'd128,  2'd3, 13'd0);
    send_item(KIND_GET,   16'h8000, 16'h7FFF, 2'd3, 13'd0);
    send_item(KIND_RAW,   16'd0,    16'd0,    2'd0, 13'd0);
    send_item(KIND_CLEAR, 16'd0,    16'd0,    2'd2, 13'd0);
    send_item(KIND_RAW,   16'd0,    16'd0,    2'd0, 13'd100);
    send_item(KIND_SET,   16'd10,   16'd10,   2'd0, 13'd0);
    send_item(KIND_GET,   16'd10,   16'd10,   2'd0, 13'd0);
    send_item(KIND_RAW,   16'd0,    16'd0,    2'd0, 13'(10 * WIDTH / 4 + 2));
    send_item(KIND_RAW,   16'd0,    16'd0,    2'd0, 13'h1FFF);

    // Phase 1: sender idles 29%, receiver 73%
    settle();
    cfg_write(2'd3);
    repeat (PHASE_ITEMS) random_item();

    // Phase 2: swapped
    settle();
    cfg_write(2'd1);
    send_idle_pct = 73;
    recv_idle_pct = 29;
    repeat (PHASE_ITEMS) random_item();

    // Phase 3: no idling, starting with a long output hold-off under a flood of reads
    settle();
    cfg_write(2'd2);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req = 1'b1;
    repeat (FLOOD_ITEMS) begin
      send_item((($urandom_range(1) == 0) ? KIND_GET : KIND_RAW),
                pick_coord(WIDTH), pick_coord(HEIGHT), 2'($urandom), 13'($urandom));
    end
    repeat (PHASE_ITEMS - FLOOD_ITEMS) random_item();
    in_valid <= 1'b0;

    // Drain and watch for stray results
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_WAIT) @(posedge clk_i);
    if (sb.expected_q.size() != 0) sb.errors++;

    $display("covered %0d clear, %0d set, %0d get, %0d raw items; %0d results checked",
             sb.kind_count[KIND_CLEAR], sb.kind_count[KIND_SET],
             sb.kind_count[KIND_GET], sb.kind_count[KIND_RAW], sb.checked);
    $display("three idle mixes, one long output hold-off, init_color 0/3/1/2; %0d mismatches",
             sb.errors);
    if (sb.errors == 0) begin
      $display("tb_packed_2bpp_framebuffer: clean");
    end else begin
      $display("tb_packed_2bpp_framebuffer: errors");
    end
    $finish;
  end

endmodule
